/* design/cau_pkg.sv */
`default_nettype none
package cau_pkg;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} cau_op_t;

	// Control that travels alongside each transaction through the divider cells
	typedef struct packed {
		logic valid;
		logic is_div;
		logic dz;
		logic neg_re;
		logic neg_im;
		logic ovf;
	} cau_ctl_t;

endpackage
`default_nettype wire

/* design/cau_front.sv */
`default_nettype none
module cau_front import cau_pkg::*; #(
	parameter int W  = 16,
	parameter int F  = 8,
	parameter int RW = 50
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   en,
	input  wire logic                   valid,
	input  wire logic [1:0]             operation,
	input  wire logic signed [W-1:0]    a_re,
	input  wire logic signed [W-1:0]    a_im,
	input  wire logic signed [W-1:0]    b_re,
	input  wire logic signed [W-1:0]    b_im,
	output cau_ctl_t                    ctl_s2,
	output logic signed [W-1:0]         res_re_s2,
	output logic signed [W-1:0]         res_im_s2,
	output logic [2*W-1:0]              den_s2,
	output logic [RW-1:0]               rem_re_s2,
	output logic [RW-1:0]               rem_im_s2
);

	localparam int PW = 2 * W;
	localparam int SW = PW + 1;
	localparam logic signed [SW-1:0] SMAX = SW'((64'sd1 <<< (W - 1)) - 64'sd1);
	localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);

	logic                 valid_s1;
	cau_op_t              op_s1;
	logic signed [PW-1:0] prr_s1, pii_s1, pri_s1, pir_s1, pbb_s1, pcc_s1;
	logic signed [W:0]    sum_re_s1, sum_im_s1;

	logic signed [PW-1:0] prr, pii, pri, pir, pbb, pcc;
	logic signed [W:0]    sum_re, sum_im;

	assign prr = a_re * b_re;
	assign pii = a_im * b_im;
	assign pri = a_re * b_im;
	assign pir = a_im * b_re;
	assign pbb = b_re * b_re;
	assign pcc = b_im * b_im;

	always_comb begin
		if (cau_op_t'(operation) == OP_ADD) begin
			sum_re = {a_re[W-1], a_re} + {b_re[W-1], b_re};
			sum_im = {a_im[W-1], a_im} + {b_im[W-1], b_im};
		end else begin
			sum_re = {a_re[W-1], a_re} - {b_re[W-1], b_re};
			sum_im = {a_im[W-1], a_im} - {b_im[W-1], b_im};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1     <= cau_op_t'(operation);
			prr_s1    <= prr;
			pii_s1    <= pii;
			pri_s1    <= pri;
			pir_s1    <= pir;
			pbb_s1    <= pbb;
			pcc_s1    <= pcc;
			sum_re_s1 <= sum_re;
			sum_im_s1 <= sum_im;
		end
	end

	function automatic logic [W:0] sat_w(input logic signed [SW-1:0] v);
		logic [W:0] r;
		if (v > SMAX) begin
			r = {1'b1, SMAX[W-1:0]};
		end else if (v < SMIN) begin
			r = {1'b1, SMIN[W-1:0]};
		end else begin
			r = {1'b0, v[W-1:0]};
		end
		return r;
	endfunction

	logic signed [SW-1:0] m_re, m_im, n_re, n_im, v_re, v_im;
	logic [SW-1:0]        mag_re, mag_im;
	logic [PW-1:0]        den;
	logic [W:0]           s_re, s_im;
	logic                 dz;
	cau_ctl_t             ctl;

	always_comb begin
		// floor shift of the product sums
		m_re   = $signed({prr_s1[PW-1], prr_s1} - {pii_s1[PW-1], pii_s1}) >>> F;
		m_im   = $signed({pri_s1[PW-1], pri_s1} + {pir_s1[PW-1], pir_s1}) >>> F;
		n_re   = {prr_s1[PW-1], prr_s1} + {pii_s1[PW-1], pii_s1};
		n_im   = {pir_s1[PW-1], pir_s1} - {pri_s1[PW-1], pri_s1};
		mag_re = n_re[SW-1] ? SW'(-n_re) : SW'(n_re);
		mag_im = n_im[SW-1] ? SW'(-n_im) : SW'(n_im);
		den    = PW'(pbb_s1) + PW'(pcc_s1);
		if (op_s1 == OP_MUL) begin
			v_re = m_re;
			v_im = m_im;
		end else begin
			v_re = SW'(sum_re_s1);
			v_im = SW'(sum_im_s1);
		end
		s_re = sat_w(v_re);
		s_im = sat_w(v_im);
		dz   = (op_s1 == OP_DIV) && (den == '0);
		ctl.valid  = valid_s1;
		ctl.is_div = (op_s1 == OP_DIV) && !dz;
		ctl.dz     = dz;
		ctl.neg_re = n_re[SW-1];
		ctl.neg_im = n_im[SW-1];
		ctl.ovf    = (op_s1 != OP_DIV) && (s_re[W] || s_im[W]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// divide by zero reports zero parts
			res_re_s2 <= dz ? '0 : s_re[W-1:0];
			res_im_s2 <= dz ? '0 : s_im[W-1:0];
			den_s2    <= den;
			rem_re_s2 <= RW'(mag_re) << F;
			rem_im_s2 <= RW'(mag_im) << F;
		end
	end

endmodule
`default_nettype wire

/* design/cau_cell.sv */
`default_nettype none
module cau_cell import cau_pkg::*; #(
	parameter int W  = 16,
	parameter int RW = 50,
	parameter int K  = 0
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  cau_ctl_t                 ctl_i,
	input  wire logic [W-1:0]        res_re_i,
	input  wire logic [W-1:0]        res_im_i,
	input  wire logic [2*W-1:0]      den_i,
	input  wire logic [RW-1:0]       rem_re_i,
	input  wire logic [RW-1:0]       rem_im_i,
	input  wire logic [W+1:0]        q_re_i,
	input  wire logic [W+1:0]        q_im_i,
	output cau_ctl_t                 ctl_q,
	output logic [W-1:0]             res_re_q,
	output logic [W-1:0]             res_im_q,
	output logic [2*W-1:0]           den_q,
	output logic [RW-1:0]            rem_re_q,
	output logic [RW-1:0]            rem_im_q,
	output logic [W+1:0]             q_re_q,
	output logic [W+1:0]             q_im_q
);

	logic [RW-1:0] dsh;
	logic          ge_re, ge_im;

	assign dsh   = RW'(den_i) << K;
	assign ge_re = rem_re_i >= dsh;
	assign ge_im = rem_im_i >= dsh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_re_q <= res_re_i;
			res_im_q <= res_im_i;
			den_q    <= den_i;
			rem_re_q <= ge_re ? rem_re_i - dsh : rem_re_i;
			rem_im_q <= ge_im ? rem_im_i - dsh : rem_im_i;
			q_re_q   <= {q_re_i[W:0], ge_re};
			q_im_q   <= {q_im_i[W:0], ge_im};
		end
	end

endmodule
`default_nettype wire

/* design/complex_arithmetic_unit.sv */
`default_nettype none
// Complex add, subtract, multiply and divide on signed fixed-point parts.
// One transaction is accepted every cycle while in_stall is low. Each passes
// through two front stages (products and sums, then saturation), a row of
// WORD_BITS+2 divider cells that each settle one quotient bit of both parts,
// and the output register. All operations take the same path, so results
// leave in order. A two-entry output buffer lets the block keep accepting
// while a result waits; in_stall rises only once that buffer holds a second
// result.
module complex_arithmetic_unit import cau_pkg::*; #(
	parameter int WORD_BITS = 16,
	parameter int FRAC_BITS = 8
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [1:0]                  operation,
	input  wire logic signed [WORD_BITS-1:0] a_re,
	input  wire logic signed [WORD_BITS-1:0] a_im,
	input  wire logic signed [WORD_BITS-1:0] b_re,
	input  wire logic signed [WORD_BITS-1:0] b_im,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic signed [WORD_BITS-1:0]      res_re,
	output logic signed [WORD_BITS-1:0]      res_im,
	output logic                             overflowed,
	output logic                             div_zero
);

	localparam int W    = WORD_BITS;
	localparam int QW   = W + 2;
	localparam int NUMW = 2 * W + 1 + FRAC_BITS;
	localparam int DSW  = 3 * W + 2;
	localparam int RW   = (NUMW > DSW) ? NUMW : DSW;
	localparam logic [QW-1:0] QMAX = QW'((64'd1 << (W - 1)) - 64'd1);

	logic en;

	cau_ctl_t      ctl  [QW+1];
	logic [W-1:0]  rre  [QW+1];
	logic [W-1:0]  rim  [QW+1];
	logic [2*W-1:0] den [QW+1];
	logic [RW-1:0] rem_re [QW+1];
	logic [RW-1:0] rem_im [QW+1];
	logic [QW-1:0] q_re [QW+1];
	logic [QW-1:0] q_im [QW+1];

	cau_front #(.W(W), .F(FRAC_BITS), .RW(RW)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid     (in_valid),
		.operation (operation),
		.a_re      (a_re),
		.a_im      (a_im),
		.b_re      (b_re),
		.b_im      (b_im),
		.ctl_s2    (ctl[0]),
		.res_re_s2 (rre[0]),
		.res_im_s2 (rim[0]),
		.den_s2    (den[0]),
		.rem_re_s2 (rem_re[0]),
		.rem_im_s2 (rem_im[0])
	);

	assign q_re[0] = '0;
	assign q_im[0] = '0;

	for (genvar i = 0; i < QW; i++) begin : g_cell
		cau_cell #(.W(W), .RW(RW), .K(QW - 1 - i)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.ctl_i    (ctl[i]),
			.res_re_i (rre[i]),
			.res_im_i (rim[i]),
			.den_i    (den[i]),
			.rem_re_i (rem_re[i]),
			.rem_im_i (rem_im[i]),
			.q_re_i   (q_re[i]),
			.q_im_i   (q_im[i]),
			.ctl_q    (ctl[i+1]),
			.res_re_q (rre[i+1]),
			.res_im_q (rim[i+1]),
			.den_q    (den[i+1]),
			.rem_re_q (rem_re[i+1]),
			.rem_im_q (rem_im[i+1]),
			.q_re_q   (q_re[i+1]),
			.q_im_q   (q_im[i+1])
		);
	end

	// Apply sign to a quotient magnitude and clamp; top bit flags saturation
	function automatic logic [W:0] div_sat(input logic [QW-1:0] q, input logic neg);
		logic [W:0] r;
		if (!neg) begin
			if (q > QMAX) begin
				r = {1'b1, 1'b0, {(W-1){1'b1}}};
			end else begin
				r = {1'b0, q[W-1:0]};
			end
		end else begin
			if (q > QMAX + QW'(1)) begin
				r = {1'b1, 1'b1, {(W-1){1'b0}}};
			end else begin
				r = {1'b0, W'(-q[W-1:0])};
			end
		end
		return r;
	endfunction

	cau_ctl_t     tail;
	logic [W:0]   d_re, d_im;
	logic [W-1:0] fin_re, fin_im;
	logic         fin_ovf;

	always_comb begin
		tail = ctl[QW];
		d_re = div_sat(q_re[QW], tail.neg_re);
		d_im = div_sat(q_im[QW], tail.neg_im);
		if (tail.is_div) begin
			fin_re  = d_re[W-1:0];
			fin_im  = d_im[W-1:0];
			fin_ovf = d_re[W] || d_im[W];
		end else begin
			fin_re  = rre[QW];
			fin_im  = rim[QW];
			fin_ovf = tail.ovf;
		end
	end

	logic         out_v_q, skid_v_q;
	logic [W-1:0] out_re_q, out_im_q, skid_re_q, skid_im_q;
	logic         out_ovf_q, out_dz_q, skid_ovf_q, skid_dz_q;
	logic         take, push;

	assign en       = !skid_v_q;
	assign in_stall = skid_v_q;
	assign take     = out_v_q && !out_stall;
	assign push     = en && tail.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (skid_v_q) begin
				if (take) begin
					skid_v_q <= 1'b0;
				end
			end else if (push) begin
				if (out_v_q && !take) begin
					skid_v_q <= 1'b1;
				end else begin
					out_v_q <= 1'b1;
				end
			end else if (take) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take) begin
				out_re_q  <= skid_re_q;
				out_im_q  <= skid_im_q;
				out_ovf_q <= skid_ovf_q;
				out_dz_q  <= skid_dz_q;
			end
		end else if (push) begin
			if (out_v_q && !take) begin
				skid_re_q  <= fin_re;
				skid_im_q  <= fin_im;
				skid_ovf_q <= fin_ovf;
				skid_dz_q  <= tail.dz;
			end else begin
				out_re_q  <= fin_re;
				out_im_q  <= fin_im;
				out_ovf_q <= fin_ovf;
				out_dz_q  <= tail.dz;
			end
		end
	end

	assign out_valid  = out_v_q;
	assign res_re     = out_re_q;
	assign res_im     = out_im_q;
	assign overflowed = out_ovf_q;
	assign div_zero   = out_dz_q;

endmodule
`default_nettype wire
